// ----- hdl/cbq_pkg.sv -----
// Shared constants and types for the cascaded biquad filter.
package cbq_pkg;

  localparam int MaxSections     = 16;
  localparam int SampleWidth     = 24;
  localparam int CoefFracBits    = 28;
  localparam int CoefWidth       = 32;
  localparam int SectionIdxWidth = 4;
  localparam int CoefSelWidth    = 4;
  localparam int SlotsPerSection = 9;
  localparam int HistTaps        = 4;
  localparam int CfgIdxWidth     = 1;
  localparam int CfgDataWidth    = 5;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_SECTION_ORDER   = 1'b0,
    CFG_SECTIONS_IN_USE = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_COEF   = 1'b1
  } req_type_e;

  typedef struct packed {
    logic clear;
    logic load;
  } mac_ctrl_t;

endpackage

// ----- hdl/cbq_req_if.sv -----
// Request channel: samples and coefficient writes.
interface cbq_req_if #(
  parameter int SAMPLE_WIDTH = 24
);
  import cbq_pkg::*;

  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic [SectionIdxWidth-1:0]     section_index;
  logic [CoefSelWidth-1:0]        coef_select;
  logic signed [CoefWidth-1:0]    coef_value;

  modport source (output valid, req_type, sample_in, section_index, coef_select, coef_value,
                  input ready);
  modport sink (input valid, req_type, sample_in, section_index, coef_select, coef_value,
                output ready);
endinterface

// ----- hdl/cbq_rsp_if.sv -----
// Response channel: filtered samples.
interface cbq_rsp_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           saturated;

  modport source (output valid, sample_out, saturated, input ready);
  modport sink (input valid, sample_out, saturated, output ready);
endinterface

// ----- hdl/cbq_mac.sv -----
// Shared multiply-accumulate with round half up and 32-bit saturation.
module cbq_mac #(
  parameter int COEF_FRAC_BITS = cbq_pkg::CoefFracBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cbq_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [cbq_pkg::CoefWidth-1:0] coef_i,
  input  logic signed [cbq_pkg::CoefWidth-1:0] data_i,
  output logic signed [cbq_pkg::CoefWidth-1:0] res_o,
  output logic                                clip_o
);
  import cbq_pkg::*;

  localparam int ProdW = 2 * CoefWidth;
  localparam int AccW  = ProdW + 4;
  localparam int ResW  = AccW - COEF_FRAC_BITS;
  localparam logic [AccW-1:0] Half = {{(AccW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

  logic signed [ProdW-1:0] prod_q;
  logic                    prod_vld_q;
  logic signed [AccW-1:0]  acc_q;
  logic [AccW-1:0]         rnd;
  logic [ResW-1:0]         quo;
  logic [ResW-CoefWidth:0] top_bits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prod_q <= coef_i * data_i;
    end
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
  end

  // floor((acc + half) / 2^F) is the upper bit field of the two's complement sum
  assign rnd      = acc_q + Half;
  assign quo      = rnd[AccW-1:COEF_FRAC_BITS];
  assign top_bits = quo[ResW-1:CoefWidth-1];
  assign clip_o   = !((&top_bits) || !(|top_bits));

  always_comb begin
    if (!clip_o) begin
      res_o = quo[CoefWidth-1:0];
    end else if (quo[ResW-1]) begin
      res_o = {1'b1, {(CoefWidth-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(CoefWidth-1){1'b1}}};
    end
  end

endmodule

// ----- hdl/cascaded_biquad_iir_filter_unit.sv -----
// Cascaded direct form I IIR filter around a shared MAC and two on-chip memories.
// Coefficient write: stored while idle, produces no result.
// Sample: each active section loads its output history, accumulates its b and a terms on the
// shared MAC, rounds, and writes back taps history words; the active sections are run in turn.
// One word in flight; the output register lets the next word be taken while a result waits.
// Reset: 2nd order, one section, input and section (valid bits) history cleared; coefs kept.
module cascaded_biquad_iir_filter_unit #(
  parameter int MAX_SECTIONS   = cbq_pkg::MaxSections,
  parameter int SAMPLE_WIDTH   = cbq_pkg::SampleWidth,
  parameter int COEF_FRAC_BITS = cbq_pkg::CoefFracBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cbq_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [cbq_pkg::CfgDataWidth-1:0] cfg_data_i,
  cbq_req_if.sink                          req_i,
  cbq_rsp_if.source                        rsp_o
);
  import cbq_pkg::*;

  localparam int SecW      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int HistDepth = (2 ** SecW) * HistTaps;
  localparam int CoefDepth = MAX_SECTIONS * SlotsPerSection;
  localparam int CoefAw    = $clog2(CoefDepth);
  localparam int AddrW     = CoefAw + 8;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MAC, S_ROUND, S_WB, S_FIN} state_e;

  state_e                         state_q;
  logic [3:0]                     step_q;
  logic [SecW-1:0]                sec_q;
  logic                           order_q;
  logic [CfgDataWidth-1:0]        nsec_q;
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [SAMPLE_WIDTH-1:0] ih_q [HistTaps];
  logic signed [CoefWidth-1:0]    prev_now_q;
  logic signed [CoefWidth-1:0]    prev_hist_q [HistTaps];
  logic signed [CoefWidth-1:0]    own_q [HistTaps];
  logic signed [CoefWidth-1:0]    cur_q;
  logic                           sat_q;
  logic                           out_v_q;
  logic signed [SAMPLE_WIDTH-1:0] out_s_q;
  logic                           out_sat_q;

  logic signed [CoefWidth-1:0] coef_mem [CoefDepth];
  logic signed [CoefWidth-1:0] coef_rd_q;
  logic signed [CoefWidth-1:0] hist_mem [HistDepth];
  logic [HistDepth-1:0]        hist_vld_q;
  logic signed [CoefWidth-1:0] hist_rd_q;
  logic                        hist_rv_q;
  logic [3:0]                  j_d1_q;
  logic                        ld_d1_q;

  logic                        req_acc;
  logic                        coef_we;
  logic [CoefAw-1:0]           coef_wa;
  logic [CoefAw-1:0]           coef_ra;
  logic [AddrW-1:0]            wa_lin;
  logic [AddrW-1:0]            ra_lin;
  logic [3:0]                  slot;
  logic [3:0]                  j_half;
  logic [1:0]                  kk;
  logic [3:0]                  last_term;
  logic [3:0]                  taps;
  logic [SecW-1:0]             n_last;
  logic                        issue;
  logic                        hist_we;
  logic [SecW+1:0]             hist_wa;
  logic [SecW+1:0]             hist_ra;
  logic signed [CoefWidth-1:0] hist_wd;
  logic signed [CoefWidth-1:0] mac_data;
  logic signed [CoefWidth-1:0] mac_res;
  logic                        mac_clip;
  logic [CoefWidth-SAMPLE_WIDTH:0] out_top;
  logic signed [SAMPLE_WIDTH-1:0]  out_clamped;
  logic                        out_clip;
  mac_ctrl_t                   mac_ctrl;

  assign req_i.ready      = (state_q == S_IDLE);
  assign req_acc          = req_i.valid && req_i.ready;
  assign rsp_o.valid      = out_v_q;
  assign rsp_o.sample_out = out_s_q;
  assign rsp_o.saturated  = out_sat_q;

  assign taps      = order_q ? 4'd4 : 4'd2;
  assign last_term = order_q ? 4'd8 : 4'd4;

  always_comb begin
    if (nsec_q == '0) begin
      n_last = '0;
    end else if (int'(nsec_q) > MAX_SECTIONS) begin
      n_last = SecW'(MAX_SECTIONS - 1);
    end else begin
      n_last = SecW'(nsec_q - 1'b1);
    end
  end

  // coefficient write address: section*9 + slot
  assign wa_lin  = (AddrW'(req_i.section_index) << 3) + AddrW'(req_i.section_index)
                 + AddrW'(req_i.coef_select);
  assign coef_wa = CoefAw'(wa_lin);
  assign coef_we = req_acc && (req_i.req_type == REQ_COEF)
                && (int'(req_i.section_index) < MAX_SECTIONS)
                && (int'(req_i.coef_select) < SlotsPerSection);

  // term j: 0 -> b0, odd -> b_k on prev history, even -> a_k on own history
  always_comb begin
    j_half = (step_q + 4'd1) >> 1;
    if (step_q == 4'd0) begin
      slot = 4'd0;
    end else if (step_q[0]) begin
      slot = j_half;
    end else begin
      slot = j_half + 4'd4;
    end
  end
  assign ra_lin  = (AddrW'(sec_q) << 3) + AddrW'(sec_q) + AddrW'(slot);
  assign coef_ra = CoefAw'(ra_lin);
  assign issue   = (state_q == S_MAC) && (step_q <= last_term);

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= req_i.coef_value;
    end
    coef_rd_q <= coef_mem[coef_ra];
  end

  assign hist_ra = {sec_q, step_q[1:0]};
  assign hist_wa = {sec_q, step_q[1:0]};
  assign hist_we = (state_q == S_WB);
  assign hist_wd = (step_q[1:0] == 2'd0) ? cur_q : own_q[step_q[1:0] - 2'd1];

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_rd_q <= hist_mem[hist_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      hist_rv_q  <= 1'b0;
      ld_d1_q    <= 1'b0;
      j_d1_q     <= '0;
    end else begin
      if (hist_we) begin
        hist_vld_q[hist_wa] <= 1'b1;
      end
      hist_rv_q <= hist_vld_q[hist_ra];
      ld_d1_q   <= issue;
      j_d1_q    <= step_q;
    end
  end

  always_comb begin
    kk = 2'(((j_d1_q + 4'd1) >> 1) - 4'd1);
    if (j_d1_q == 4'd0) begin
      mac_data = prev_now_q;
    end else if (j_d1_q[0]) begin
      mac_data = prev_hist_q[kk];
    end else begin
      mac_data = own_q[kk];
    end
  end

  assign mac_ctrl.clear = (state_q == S_LOAD);
  assign mac_ctrl.load  = ld_d1_q;

  cbq_mac #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_cbq_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (coef_rd_q),
    .data_i (mac_data),
    .res_o  (mac_res),
    .clip_o (mac_clip)
  );

  assign out_top  = prev_now_q[CoefWidth-1:SAMPLE_WIDTH-1];
  assign out_clip = !((&out_top) || !(|out_top));
  always_comb begin
    if (!out_clip) begin
      out_clamped = prev_now_q[SAMPLE_WIDTH-1:0];
    end else if (prev_now_q[CoefWidth-1]) begin
      out_clamped = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      out_clamped = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      step_q     <= '0;
      sec_q      <= '0;
      order_q    <= 1'b0;
      nsec_q     <= CfgDataWidth'(1);
      x_q        <= '0;
      ih_q       <= '{default: '0};
      prev_now_q <= '0;
      prev_hist_q <= '{default: '0};
      own_q      <= '{default: '0};
      cur_q      <= '0;
      sat_q      <= 1'b0;
      out_v_q    <= 1'b0;
      out_s_q    <= '0;
      out_sat_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SECTION_ORDER:   order_q <= cfg_data_i[0];
          CFG_SECTIONS_IN_USE: nsec_q  <= cfg_data_i;
          default: ;
        endcase
      end
      // S_FIN handles the output register itself
      if (out_v_q && rsp_o.ready && (state_q != S_FIN)) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_acc && (req_i.req_type == REQ_SAMPLE)) begin
            x_q        <= req_i.sample_in;
            prev_now_q <= CoefWidth'(req_i.sample_in);
            for (int k = 0; k < HistTaps; k++) begin
              prev_hist_q[k] <= CoefWidth'(ih_q[k]);
            end
            sec_q   <= '0;
            sat_q   <= 1'b0;
            step_q  <= '0;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (step_q != 4'd0) begin
            own_q[step_q[1:0] - 2'd1] <= hist_rv_q ? hist_rd_q : '0;
          end
          if (step_q == 4'd4) begin
            step_q  <= '0;
            state_q <= S_MAC;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        S_MAC: begin
          // the steps past the last term drain the read and multiply stages
          if (step_q == last_term + 4'd2) begin
            state_q <= S_ROUND;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        S_ROUND: begin
          cur_q   <= mac_res;
          sat_q   <= sat_q | mac_clip;
          step_q  <= '0;
          state_q <= S_WB;
        end
        S_WB: begin
          if (step_q == taps - 4'd1) begin
            prev_now_q  <= cur_q;
            prev_hist_q <= own_q;
            step_q      <= '0;
            if (sec_q == n_last) begin
              state_q <= S_FIN;
            end else begin
              sec_q   <= sec_q + 1'b1;
              state_q <= S_LOAD;
            end
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        S_FIN: begin
          if (!out_v_q || rsp_o.ready) begin
            out_v_q   <= 1'b1;
            out_s_q   <= out_clamped;
            out_sat_q <= sat_q | out_clip;
            if (order_q) begin
              ih_q[3] <= ih_q[2];
              ih_q[2] <= ih_q[1];
            end
            ih_q[1] <= ih_q[0];
            ih_q[0] <= x_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/cbq_checker.sv -----
// Port-level checks for the cascaded biquad filter, bound to the top level.
module cbq_checker #(
  parameter int SAMPLE_WIDTH = cbq_pkg::SampleWidth
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    in_req_type_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [SAMPLE_WIDTH-1:0] out_sample_i,
  input logic                    out_sat_i
);
  import cbq_pkg::*;

  logic acc_coef;
  logic acc_sample;

  assign acc_coef   = in_valid_i && in_ready_i && (in_req_type_i == REQ_COEF);
  assign acc_sample = in_valid_i && in_ready_i && (in_req_type_i == REQ_SAMPLE);

  // coefficient writes never produce a word
  a_coef_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_coef && !out_valid_i |=> !out_valid_i)
    else $error("coefficient write produced an output word");

  // a sample keeps the block busy
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_sample |=> !in_ready_i)
    else $error("ready stayed high after a sample was taken");

  // a result appears only at the end of processing, never while idle
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("output word appeared while idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sample_i) && $stable(out_sat_i))
    else $error("stalled output word changed");

endmodule

bind cascaded_biquad_iir_filter_unit cbq_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_cbq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .in_req_type_i (req_i.req_type),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .out_sample_i  (rsp_o.sample_out),
  .out_sat_i     (rsp_o.saturated)
);
